// ===== design/assert_macros.svh =====
// Assertion macros shared by the heap queue design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== design/bmhq_pkg.sv =====
// Package with the types and constants of the binary min-heap queue.
package bmhq_pkg;
   localparam int Capacity = 256;
   localparam int AddrW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);
   localparam int DataW = 64;
   localparam int CountW = 9;
   localparam int QDepth = 2;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [DataW-1:0] prio;
      logic [DataW-1:0] val;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_WR,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD0,
      ST_POP_RDL,
      ST_POP_WR0,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DN_CMP2,
      ST_HEAD_RD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             ok;
      logic [DataW-1:0] popped;
      logic [DataW-1:0] head_prio;
      logic [DataW-1:0] head_val;
      logic [CntW-1:0]  count;
   } rsp_type;

   function automatic logic prio_less(logic [DataW-1:0] a, logic [DataW-1:0] b);
      prio_less = $signed(a) < $signed(b);
   endfunction
endpackage

// ===== design/bmhq_front.sv =====
// Front end: accepts commands into a short queue ahead of the heap engine.
module bmhq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bmhq_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop_ready,
   output logic              pop_valid,
   output bmhq_pkg::cmd_type pop_cmd,
   output logic              pending_ff
);
   localparam int PtrW = $clog2(bmhq_pkg::QDepth);
   bmhq_pkg::cmd_type q_ff [bmhq_pkg::QDepth];
   logic [PtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PtrW:0]   n_ff, n_in;
   logic            pending_in;
   logic            do_wr, do_rd;

   assign full      = (n_ff == PtrW'(0) + (PtrW+1)'(bmhq_pkg::QDepth));
   assign pop_valid = (n_ff != '0);
   assign pop_cmd   = q_ff[rp_ff];
   assign do_wr     = push_valid && !full;
   assign do_rd     = pop_valid && pop_ready;

   always_comb begin
      wp_in = do_wr ? wp_ff + PtrW'(1) : wp_ff;
      rp_in = do_rd ? rp_ff + PtrW'(1) : rp_ff;
      n_in  = n_ff + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
      pending_in = (n_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff <= n_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end
endmodule

// ===== design/bmhq_engine.sv =====
// Back end: sequencer that runs push sift-up and pop sift-down on the heap memory.
module bmhq_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bmhq_pkg::cmd_type cmd,
   output logic              cmd_ready,
   output logic              busy_eng,
   output logic              done,
   output bmhq_pkg::rsp_type rsp
);
   localparam int AW = bmhq_pkg::AddrW;
   localparam int CW = bmhq_pkg::CntW;
   localparam int DW = bmhq_pkg::DataW;

   logic [2*DW-1:0] mem [bmhq_pkg::Capacity];
   logic [2*DW-1:0] rd_ff;
   logic [AW-1:0]   ra;
   logic            re;
   logic [AW-1:0]   wa;
   logic [2*DW-1:0] wd;
   logic            we;

   bmhq_pkg::state_type st_ff, st_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  i_ff, i_in;      // current position
   logic [CW-1:0]  j_ff, j_in;      // candidate position
   logic [2*DW-1:0] cur_ff, cur_in; // moving pair
   logic [2*DW-1:0] best_ff, best_in;
   logic [DW-1:0]  popped_ff, popped_in;
   logic           ok_ff, ok_in;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   assign cmd_ready = (st_ff == bmhq_pkg::ST_IDLE);
   assign busy_eng  = (st_ff != bmhq_pkg::ST_IDLE);
   assign done      = (st_ff == bmhq_pkg::ST_DONE);

   always_comb begin
      rsp.ok     = ok_ff;
      rsp.popped = popped_ff;
      rsp.count  = cnt_ff;
      rsp.head_prio = (cnt_ff == '0) ? '0 : rd_ff[2*DW-1:DW];
      rsp.head_val  = (cnt_ff == '0) ? '0 : rd_ff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bmhq_pkg::ST_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      cur_ff <= cur_in;
      best_ff <= best_in;
      popped_ff <= popped_in;
      ok_ff <= ok_in;
   end

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      cur_in = cur_ff;
      best_in = best_ff;
      popped_in = popped_ff;
      ok_in = ok_ff;
      re = 1'b0;
      ra = '0;
      we = 1'b0;
      wa = '0;
      wd = cur_ff;
      case (st_ff)
         bmhq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               popped_in = '0;
               cur_in = {cmd.prio, cmd.val};
               if (cmd.op == bmhq_pkg::OP_PUSH) begin
                  if (cnt_ff == CW'(bmhq_pkg::Capacity)) begin
                     ok_in = 1'b0;
                     st_in = bmhq_pkg::ST_HEAD_RD;
                  end else begin
                     ok_in = 1'b1;
                     i_in = cnt_ff;
                     cnt_in = cnt_ff + CW'(1);
                     st_in = bmhq_pkg::ST_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     ok_in = 1'b0;
                     st_in = bmhq_pkg::ST_HEAD_RD;
                  end else begin
                     ok_in = 1'b1;
                     cnt_in = cnt_ff - CW'(1);
                     st_in = bmhq_pkg::ST_POP_RD0;
                  end
               end
            end
         end
         // Sift-up: the new pair rides in cur and is written once it settles.
         bmhq_pkg::ST_UP_RD: begin
            if (i_ff == '0) begin
               st_in = bmhq_pkg::ST_PUSH_WR;
            end else begin
               j_in = (i_ff - CW'(1)) >> 1;
               re = 1'b1;
               ra = AW'((i_ff - CW'(1)) >> 1);
               st_in = bmhq_pkg::ST_UP_CMP;
            end
         end
         bmhq_pkg::ST_UP_CMP: begin
            if (bmhq_pkg::prio_less(cur_ff[2*DW-1:DW], rd_ff[2*DW-1:DW])) begin
               we = 1'b1;
               wa = AW'(i_ff);
               wd = rd_ff;
               i_in = j_ff;
               st_in = bmhq_pkg::ST_UP_RD;
            end else begin
               st_in = bmhq_pkg::ST_PUSH_WR;
            end
         end
         bmhq_pkg::ST_PUSH_WR: begin
            we = 1'b1;
            wa = AW'(i_ff);
            wd = cur_ff;
            st_in = bmhq_pkg::ST_HEAD_RD;
         end
         // Pop: fetch the root, then the last pair, which sifts down from the root.
         bmhq_pkg::ST_POP_RD0: begin
            re = 1'b1;
            ra = '0;
            st_in = bmhq_pkg::ST_POP_RDL;
         end
         bmhq_pkg::ST_POP_RDL: begin
            popped_in = rd_ff[DW-1:0];
            re = 1'b1;
            ra = AW'(cnt_ff);
            i_in = '0;
            st_in = bmhq_pkg::ST_POP_WR0;
         end
         bmhq_pkg::ST_POP_WR0: begin
            cur_in = rd_ff;
            st_in = bmhq_pkg::ST_DN_RD;
         end
         bmhq_pkg::ST_DN_RD: begin
            j_in = (i_ff << 1) + CW'(1);
            if ((i_ff << 1) + CW'(1) >= cnt_ff || i_ff >= CW'(bmhq_pkg::Capacity / 2)) begin
               st_in = bmhq_pkg::ST_PUSH_WR;
            end else begin
               re = 1'b1;
               ra = AW'((i_ff << 1) + CW'(1));
               st_in = bmhq_pkg::ST_DN_CMP;
            end
         end
         bmhq_pkg::ST_DN_CMP: begin
            // Left child read back; keep it as the choice if strictly smaller.
            best_in = rd_ff;
            if (bmhq_pkg::prio_less(rd_ff[2*DW-1:DW], cur_ff[2*DW-1:DW])) begin
               best_in = rd_ff;
            end else begin
               best_in = cur_ff;
            end
            if (j_ff + CW'(1) < cnt_ff) begin
               re = 1'b1;
               ra = AW'(j_ff + CW'(1));
               st_in = bmhq_pkg::ST_DN_CMP2;
            end else if (bmhq_pkg::prio_less(rd_ff[2*DW-1:DW], cur_ff[2*DW-1:DW])) begin
               we = 1'b1;
               wa = AW'(i_ff);
               wd = rd_ff;
               i_in = j_ff;
               st_in = bmhq_pkg::ST_DN_RD;
            end else begin
               st_in = bmhq_pkg::ST_PUSH_WR;
            end
         end
         bmhq_pkg::ST_DN_CMP2: begin
            if (bmhq_pkg::prio_less(rd_ff[2*DW-1:DW], best_ff[2*DW-1:DW])) begin
               we = 1'b1;
               wa = AW'(i_ff);
               wd = rd_ff;
               i_in = j_ff + CW'(1);
               st_in = bmhq_pkg::ST_DN_RD;
            end else if (best_ff != cur_ff ||
                         bmhq_pkg::prio_less(best_ff[2*DW-1:DW], cur_ff[2*DW-1:DW])) begin
               we = 1'b1;
               wa = AW'(i_ff);
               wd = best_ff;
               i_in = j_ff;
               st_in = bmhq_pkg::ST_DN_RD;
            end else begin
               st_in = bmhq_pkg::ST_PUSH_WR;
            end
         end
         bmhq_pkg::ST_HEAD_RD: begin
            re = 1'b1;
            ra = '0;
            st_in = bmhq_pkg::ST_DONE;
         end
         bmhq_pkg::ST_DONE: begin
            st_in = bmhq_pkg::ST_IDLE;
         end
         default: begin
            st_in = bmhq_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

// ===== design/binary_min_heap_queue.sv =====
// Top level of the binary min-heap priority queue.
//
//   Channel   Direction  Handshake               Beat contents
//   request   in         start & !busy           req_op, req_priority_req, req_payload
//   response  out        rsp_strobe, one cycle   ok, popped value, head pair, count, empty
//
// From one accepting edge to the next, a push runs the queue hop, a parent read and
// compare per sift-up level, the final write, the head read and the strobe. A pop
// reads root and last pair, then a left read, right read and compare per sift-down
// level; a refused push or an empty pop goes straight to the head read and strobe.
// Reset is synchronous and empties the heap; memory contents need no clearing.
// The receiver cannot stall, so each response beat is shown for exactly one cycle.
module binary_min_heap_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [63:0] req_priority_req,
   input  logic [63:0] req_payload,
   output logic        rsp_strobe,
   output logic        rsp_ok,
   output logic [63:0] rsp_popped_value,
   output logic [63:0] rsp_head_priority,
   output logic [63:0] rsp_head_value,
   output logic [8:0]  rsp_count,
   output logic        rsp_is_empty
);
`include "assert_macros.svh"

   bmhq_pkg::cmd_type in_cmd, q_cmd;
   bmhq_pkg::rsp_type eng_rsp;
   logic q_full, q_valid, q_ready, q_pending, eng_busy, eng_done;
   logic accept;

   // One command in flight: the front refuses a new beat until its result has left.
   assign busy   = q_full || q_pending || eng_busy;
   assign accept = start && !busy;

   assign in_cmd.op   = bmhq_pkg::op_type'(req_op);
   assign in_cmd.prio = req_priority_req;
   assign in_cmd.val  = req_payload;

   bmhq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_cmd   (in_cmd),
      .full       (q_full),
      .pop_ready  (q_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pending_ff (q_pending)
   );

   bmhq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_ready (q_ready),
      .busy_eng  (eng_busy),
      .done      (eng_done),
      .rsp       (eng_rsp)
   );

   assign rsp_strobe        = eng_done;
   assign rsp_ok            = eng_rsp.ok;
   assign rsp_popped_value  = eng_rsp.popped;
   assign rsp_head_priority = eng_rsp.head_prio;
   assign rsp_head_value    = eng_rsp.head_val;
   assign rsp_count         = 9'(eng_rsp.count);
   assign rsp_is_empty      = (eng_rsp.count == '0);

   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "accepted beat did not raise busy")
   `ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, busy, "response while idle")
   `ASSERT_IMPL(a_cap, clock, reset, 1'b1, rsp_count <= 9'(bmhq_pkg::Capacity),
                "count beyond capacity")
endmodule
